/* src/assert_macros.svh */
// Assertion macros shared by the sorted set RTL.
// Every macro samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every clock edge outside reset.
`define SUSI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition at one edge implies a property at the next edge.
`define SUSI_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

/* src/susi_pkg.sv */
// Package for the sorted set insert block: sizes, codes and transfer types.
// Used by susi_cell and sorted_unique_set_insert; depends on nothing.
package susi_pkg;

  localparam int DEPTH   = 8;
  localparam int VALUE_W = 16;
  localparam int POS_W   = 3;
  localparam int CNT_W   = 4;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DUP  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic               kind;
    logic [VALUE_W-1:0] new_value;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [POS_W-1:0] position;
    logic [CNT_W-1:0] entry_count;
  } rsp_t;

  // Broadcast from the control to every cell.
  typedef struct packed {
    logic               write;
    logic [VALUE_W-1:0] value;
  } cell_cmd_t;

  // Compare flags that each cell reports.
  typedef struct packed {
    logic lt;
    logic eq;
  } cell_flags_t;

endpackage

/* src/sorted_unique_set_insert.sv */
// Top level of the sorted set insert block: handshakes, count and cell chain.
// Depends on susi_pkg, susi_cell and assert_macros.svh.
//
//   Channel   Signals                   Payload
//   request   req_valid, req_stall      req : susi_pkg::req_t
//   result    rsp_valid, rsp_stall      rsp : susi_pkg::rsp_t
//
// All cells compare in parallel; a write shifts them in the same edge that
// accepts the insert, and that edge registers the result for the next cycle.
// A new request transfer is taken in every cycle unless the result register
// holds a result that is stalled. Reset empties the set and drops any result.
`include "assert_macros.svh"

module sorted_unique_set_insert (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  susi_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output susi_pkg::rsp_t rsp
);

  logic [susi_pkg::CNT_W-1:0]   count;
  logic [susi_pkg::CNT_W-1:0]   count_next;
  logic [susi_pkg::CNT_W-1:0]   lt_total;
  logic                         accept;
  logic                         dup;
  logic                         full;
  logic [susi_pkg::DEPTH-1:0]   lt_vec;
  logic [susi_pkg::DEPTH-1:0]   eq_vec;
  logic [susi_pkg::DEPTH-1:0]   held_vec;
  logic [susi_pkg::VALUE_W-1:0] values [susi_pkg::DEPTH];
  susi_pkg::cell_flags_t        flags [susi_pkg::DEPTH];
  susi_pkg::cell_cmd_t          cmd;
  susi_pkg::rsp_t               rsp_next;

  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;

  for (genvar i = 0; i < susi_pkg::DEPTH; i++) begin : g_cell
    assign held_vec[i] = count > susi_pkg::CNT_W'(i);
    assign lt_vec[i]   = flags[i].lt;
    assign eq_vec[i]   = flags[i].eq;
    if (i == 0) begin : g_head
      susi_cell u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .held       (held_vec[i]),
        .left_lt    (1'b1),
        .left_value (cmd.value),
        .value      (values[i]),
        .flags      (flags[i])
      );
    end else begin : g_body
      susi_cell u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .held       (held_vec[i]),
        .left_lt    (flags[i-1].lt),
        .left_value (values[i-1]),
        .value      (values[i]),
        .flags      (flags[i])
      );
    end
  end

  always_comb begin
    lt_total = '0;
    for (int i = 0; i < susi_pkg::DEPTH; i++) begin
      lt_total = lt_total + susi_pkg::CNT_W'(lt_vec[i]);
    end
    dup  = |eq_vec;
    full = count == susi_pkg::CNT_W'(susi_pkg::DEPTH);

    cmd.value = req.new_value;
    cmd.write = accept && (req.kind == susi_pkg::KIND_INSERT) && !dup && !full;

    count_next = count;
    rsp_next.status   = susi_pkg::ST_OK;
    rsp_next.position = '0;
    if (req.kind == susi_pkg::KIND_CLEAR) begin
      count_next = '0;
    end else if (dup) begin
      rsp_next.status   = susi_pkg::ST_DUP;
      rsp_next.position = lt_total[susi_pkg::POS_W-1:0];
    end else if (full) begin
      rsp_next.status = susi_pkg::ST_FULL;
    end else begin
      count_next        = count + susi_pkg::CNT_W'(1);
      rsp_next.position = lt_total[susi_pkg::POS_W-1:0];
    end
    rsp_next.entry_count = count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

  `SUSI_ASSERT(a_count_bound, count <= susi_pkg::CNT_W'(susi_pkg::DEPTH), "count beyond depth")
  `SUSI_ASSERT(a_sorted, $onehot0({1'b0, lt_vec} + (susi_pkg::DEPTH+1)'(1)), "held entries out of order")
  `SUSI_ASSERT(a_unique, $onehot0(eq_vec), "value held more than once")
  `SUSI_ASSERT_NEXT(a_clear, accept && req.kind == susi_pkg::KIND_CLEAR, count == '0, "clear left entries")
  `SUSI_ASSERT_NEXT(a_grow, cmd.write, count == $past(count) + susi_pkg::CNT_W'(1), "insert did not grow count")

endmodule

/* src/susi_cell.sv */
// One cell of the sorted set chain: holds one entry, compares it with the
// broadcast value and, on a write, keeps, replaces or takes its left neighbor.
// Depends on susi_pkg.
module susi_cell (
  input  logic                        clk,
  input  susi_pkg::cell_cmd_t         cmd,
  input  logic                        held,
  input  logic                        left_lt,
  input  logic [susi_pkg::VALUE_W-1:0] left_value,
  output logic [susi_pkg::VALUE_W-1:0] value,
  output susi_pkg::cell_flags_t       flags
);

  logic [susi_pkg::VALUE_W-1:0] value_next;

  always_comb begin
    flags.lt = held && (value < cmd.value);
    flags.eq = held && (value == cmd.value);
    if (flags.lt) begin
      value_next = value;
    end else if (left_lt) begin
      value_next = cmd.value;
    end else begin
      value_next = left_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      value <= value_next;
    end
  end

endmodule
